>>> rtl/kadr_pkg.sv
// ----------------------------------------------------------------------------
// Key auto-repeat direction resolver package
// Shared sizes, codes and payload types of the key repeat and direction logic.
// ----------------------------------------------------------------------------
package kadr_pkg;

    localparam int KEYS         = 16;
    localparam int COUNT_BITS   = 16;
    localparam int MASK_BITS    = 16;
    localparam int REG_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int DIR_BITS     = 4;
    localparam int DIRS         = 4;

    localparam int KEY_IDX_BITS = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int STEP_MAX     = (COUNT_BITS > KEYS) ? COUNT_BITS : KEYS;
    localparam int STEP_BITS    = $clog2(STEP_MAX);
    localparam int WIDE_BITS    = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
    localparam int REM_BITS     = WIDE_BITS + 1;

    localparam logic [COUNT_BITS-1:0] HOLD_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DELAY    = 3'd0,
        REG_INTERVAL = 3'd1,
        REG_DOWN     = 3'd2,
        REG_LEFT     = 3'd3,
        REG_RIGHT    = 3'd4,
        REG_UP       = 3'd5
    } t_reg_idx;

    localparam logic [REG_BITS-1:0] RESET_DELAY    = 16'd20;
    localparam logic [REG_BITS-1:0] RESET_INTERVAL = 16'd10;
    localparam logic [REG_BITS-1:0] RESET_DOWN     = 16'd1;
    localparam logic [REG_BITS-1:0] RESET_LEFT     = 16'd2;
    localparam logic [REG_BITS-1:0] RESET_RIGHT    = 16'd4;
    localparam logic [REG_BITS-1:0] RESET_UP       = 16'd8;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [DIR_BITS-1:0] DIR_NONE  = 4'd0;
    localparam logic [DIR_BITS-1:0] DIR_DL    = 4'd1;
    localparam logic [DIR_BITS-1:0] DIR_DOWN  = 4'd2;
    localparam logic [DIR_BITS-1:0] DIR_DR    = 4'd3;
    localparam logic [DIR_BITS-1:0] DIR_LEFT  = 4'd4;
    localparam logic [DIR_BITS-1:0] DIR_RIGHT = 4'd6;
    localparam logic [DIR_BITS-1:0] DIR_UL    = 4'd7;
    localparam logic [DIR_BITS-1:0] DIR_UP    = 4'd8;
    localparam logic [DIR_BITS-1:0] DIR_UR    = 4'd9;

    typedef logic [COUNT_BITS-1:0] t_hold;
    typedef logic [DIRS-1:0][MASK_BITS-1:0] t_dir_masks;

    typedef struct packed {
        logic                 opcode;
        logic [MASK_BITS-1:0] key_levels;
    } t_in_req;

    typedef struct packed {
        logic [MASK_BITS-1:0] pressed_mask;
        logic [MASK_BITS-1:0] triggered_mask;
        logic [MASK_BITS-1:0] repeated_mask;
        logic [MASK_BITS-1:0] released_mask;
        logic [DIR_BITS-1:0]  dir_four;
        logic [DIR_BITS-1:0]  dir_eight;
    } t_out_res;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } t_lane_ctl;

    typedef struct packed {
        logic  pressed;
        logic  triggered;
        logic  repeated;
        logic  released;
        t_hold hold;
    } t_lane_stat;

endpackage

>>> rtl/kadr_lane.sv
// ----------------------------------------------------------------------------
// Key lane
// Hold counter of one key with a bit-serial remainder unit for the repeat test.
// ----------------------------------------------------------------------------
module kadr_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kadr_pkg::t_lane_ctl                i_ctl,
    input  logic                               i_level,
    input  logic [kadr_pkg::REG_BITS-1:0]      i_delay,
    input  logic [kadr_pkg::REG_BITS-1:0]      i_interval,
    output kadr_pkg::t_lane_stat               o_stat
);

    kadr_pkg::t_hold                      r_hold;
    kadr_pkg::t_hold                      n_hold;
    logic                                 r_rel;
    kadr_pkg::t_hold                      r_shift;
    logic [kadr_pkg::REM_BITS-1:0]        r_rem;
    logic [kadr_pkg::REM_BITS-1:0]        w_rem_sh;
    logic [kadr_pkg::REM_BITS-1:0]        w_ivl;
    logic [kadr_pkg::WIDE_BITS-1:0]       w_hold_w;
    logic [kadr_pkg::WIDE_BITS-1:0]       w_delay_w;

    always_comb begin
        if (i_ctl.clear || !i_level) begin
            n_hold = '0;
        end else if (r_hold == kadr_pkg::HOLD_MAX) begin
            n_hold = r_hold;
        end else begin
            n_hold = r_hold + kadr_pkg::COUNT_BITS'(1);
        end
    end

    assign w_rem_sh  = {r_rem[kadr_pkg::REM_BITS-2:0], r_shift[kadr_pkg::COUNT_BITS-1]};
    assign w_ivl     = kadr_pkg::REM_BITS'(i_interval);
    assign w_hold_w  = kadr_pkg::WIDE_BITS'(r_hold);
    assign w_delay_w = kadr_pkg::WIDE_BITS'(i_delay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
            r_rel  <= 1'b0;
        end else if (i_ctl.load) begin
            r_hold <= n_hold;
            r_rel  <= !i_ctl.clear && !i_level && (r_hold != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift <= n_hold;
            r_rem   <= '0;
        end else if (i_ctl.step) begin
            r_shift <= r_shift << 1;
            r_rem   <= (w_rem_sh >= w_ivl) ? (w_rem_sh - w_ivl) : w_rem_sh;
        end
    end

    always_comb begin
        o_stat.hold      = r_hold;
        o_stat.pressed   = (r_hold != '0);
        o_stat.triggered = (r_hold == kadr_pkg::COUNT_BITS'(1));
        o_stat.released  = r_rel;
        o_stat.repeated  = o_stat.triggered ||
                           (o_stat.pressed && (i_interval != '0) &&
                            (w_hold_w >= w_delay_w) && (r_rem == '0));
    end

endmodule

>>> rtl/kadr_merge.sv
// ----------------------------------------------------------------------------
// Direction merge
// Scans the key lanes for the longest hold per direction and resolves the
// four-way and eight-way directions.
// ----------------------------------------------------------------------------
module kadr_merge (
    input  logic                                  i_clk,
    input  logic                                  i_start,
    input  logic                                  i_scan,
    input  logic [kadr_pkg::KEY_IDX_BITS-1:0]     i_idx,
    input  kadr_pkg::t_hold                       i_holds [kadr_pkg::KEYS],
    input  kadr_pkg::t_dir_masks                  i_masks,
    output logic [kadr_pkg::DIR_BITS-1:0]         o_dir_four,
    output logic [kadr_pkg::DIR_BITS-1:0]         o_dir_eight
);

    localparam logic [kadr_pkg::DIR_BITS-1:0] DIR_CODE [kadr_pkg::DIRS] = '{
        kadr_pkg::DIR_DOWN, kadr_pkg::DIR_LEFT, kadr_pkg::DIR_RIGHT, kadr_pkg::DIR_UP
    };

    kadr_pkg::t_hold        r_best [kadr_pkg::DIRS];
    kadr_pkg::t_hold        w_hold;
    logic [6:0]             w_idx_ext;
    logic [kadr_pkg::DIRS-1:0] w_member;
    logic [kadr_pkg::DIRS-1:0] w_nz;

    assign w_hold    = i_holds[i_idx];
    assign w_idx_ext = 7'(i_idx);

    always_comb begin
        for (int d = 0; d < kadr_pkg::DIRS; d++) begin
            w_member[d] = (w_idx_ext < 7'(kadr_pkg::MASK_BITS)) &&
                          i_masks[d][w_idx_ext[3:0]];
            w_nz[d]     = (r_best[d] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < kadr_pkg::DIRS; d++) begin
            if (i_start) begin
                r_best[d] <= '0;
            end else if (i_scan && w_member[d] && (w_hold > r_best[d])) begin
                r_best[d] <= w_hold;
            end
        end
    end

    always_comb begin
        kadr_pkg::t_hold                 v_e;
        logic [kadr_pkg::DIR_BITS-1:0]   v_d4;
        logic [kadr_pkg::DIR_BITS-1:0]   v_d8;
        v_e  = '0;
        v_d4 = kadr_pkg::DIR_NONE;
        v_d8 = kadr_pkg::DIR_NONE;
        if (!(w_nz[0] && w_nz[3]) && !(w_nz[1] && w_nz[2])) begin
            for (int d = 0; d < kadr_pkg::DIRS; d++) begin
                if (w_nz[d] && ((v_e == '0) || (r_best[d] < v_e))) begin
                    v_d4 = DIR_CODE[d];
                    v_e  = r_best[d];
                end
            end
            if (w_nz[3] && w_nz[2]) begin
                v_d8 = kadr_pkg::DIR_UR;
            end else if (w_nz[3] && w_nz[1]) begin
                v_d8 = kadr_pkg::DIR_UL;
            end else if (w_nz[0] && w_nz[2]) begin
                v_d8 = kadr_pkg::DIR_DR;
            end else if (w_nz[0] && w_nz[1]) begin
                v_d8 = kadr_pkg::DIR_DL;
            end else begin
                v_d8 = v_d4;
            end
        end
        o_dir_four  = v_d4;
        o_dir_eight = v_d8;
    end

endmodule

>>> rtl/key_autorepeat_direction_resolver.sv
// ----------------------------------------------------------------------------
// Key auto-repeat direction resolver
// Per-key hold counters with typematic repeat and four/eight-way direction.
// ----------------------------------------------------------------------------
// A tick request has every key lane run a bit-serial remainder of its hold
// count, and then the direction merge walks the keys one per cycle. A clear
// request skips both and gives an all-zero result. One request is in work
// at a time, and a finished result waits in the output register while the
// next request is processed.
module key_autorepeat_direction_resolver (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  kadr_pkg::t_in_req                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output kadr_pkg::t_out_res                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [kadr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [kadr_pkg::REG_BITS-1:0]        i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                              r_state;
    logic [kadr_pkg::STEP_BITS-1:0]      r_step;
    logic                                r_clear;
    logic                                r_out_valid;
    kadr_pkg::t_out_res                  r_out;

    logic [kadr_pkg::REG_BITS-1:0]       r_delay;
    logic [kadr_pkg::REG_BITS-1:0]       r_interval;
    kadr_pkg::t_dir_masks                r_masks;

    logic                                w_accept;
    logic                                w_out_free;
    kadr_pkg::t_lane_ctl                 w_ctl;
    kadr_pkg::t_lane_stat                w_stat [kadr_pkg::KEYS];
    kadr_pkg::t_hold                     w_holds [kadr_pkg::KEYS];
    logic [kadr_pkg::MASK_BITS-1:0]      w_pressed;
    logic [kadr_pkg::MASK_BITS-1:0]      w_trig;
    logic [kadr_pkg::MASK_BITS-1:0]      w_rep;
    logic [kadr_pkg::MASK_BITS-1:0]      w_rel;
    logic [kadr_pkg::DIR_BITS-1:0]       w_dir_four;
    logic [kadr_pkg::DIR_BITS-1:0]       w_dir_eight;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_ctl.load  = w_accept;
    assign w_ctl.clear = w_accept && (i_in_data.opcode == kadr_pkg::OP_CLEAR);
    assign w_ctl.step  = (r_state == ST_REM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= kadr_pkg::RESET_DELAY;
            r_interval <= kadr_pkg::RESET_INTERVAL;
            r_masks[0] <= kadr_pkg::RESET_DOWN;
            r_masks[1] <= kadr_pkg::RESET_LEFT;
            r_masks[2] <= kadr_pkg::RESET_RIGHT;
            r_masks[3] <= kadr_pkg::RESET_UP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kadr_pkg::REG_DELAY:    r_delay    <= i_cfg_data;
                kadr_pkg::REG_INTERVAL: r_interval <= i_cfg_data;
                kadr_pkg::REG_DOWN:     r_masks[0] <= i_cfg_data;
                kadr_pkg::REG_LEFT:     r_masks[1] <= i_cfg_data;
                kadr_pkg::REG_RIGHT:    r_masks[2] <= i_cfg_data;
                kadr_pkg::REG_UP:       r_masks[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < kadr_pkg::KEYS; k++) begin : g_lane
        logic w_level;
        if (k < kadr_pkg::MASK_BITS) begin : g_lvl
            assign w_level = i_in_data.key_levels[k];
        end else begin : g_nolvl
            assign w_level = 1'b0;
        end
        kadr_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_level    (w_level),
            .i_delay    (r_delay),
            .i_interval (r_interval),
            .o_stat     (w_stat[k])
        );
        assign w_holds[k] = w_stat[k].hold;
    end

    for (genvar b = 0; b < kadr_pkg::MASK_BITS; b++) begin : g_mask
        if (b < kadr_pkg::KEYS) begin : g_key
            assign w_pressed[b] = w_stat[b].pressed;
            assign w_trig[b]    = w_stat[b].triggered;
            assign w_rep[b]     = w_stat[b].repeated;
            assign w_rel[b]     = w_stat[b].released;
        end else begin : g_pad
            assign w_pressed[b] = 1'b0;
            assign w_trig[b]    = 1'b0;
            assign w_rep[b]     = 1'b0;
            assign w_rel[b]     = 1'b0;
        end
    end

    kadr_merge u_merge (
        .i_clk       (i_clk),
        .i_start     (w_accept),
        .i_scan      (r_state == ST_SCAN),
        .i_idx       (r_step[kadr_pkg::KEY_IDX_BITS-1:0]),
        .i_holds     (w_holds),
        .i_masks     (r_masks),
        .o_dir_four  (w_dir_four),
        .o_dir_eight (w_dir_eight)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_step  <= '0;
                        r_clear <= (i_in_data.opcode == kadr_pkg::OP_CLEAR);
                        r_state <= (i_in_data.opcode == kadr_pkg::OP_CLEAR) ? ST_DONE : ST_REM;
                    end
                end
                ST_REM: begin
                    if (r_step == kadr_pkg::STEP_BITS'(kadr_pkg::COUNT_BITS - 1)) begin
                        r_step  <= '0;
                        r_state <= ST_SCAN;
                    end else begin
                        r_step <= r_step + kadr_pkg::STEP_BITS'(1);
                    end
                end
                ST_SCAN: begin
                    if (r_step == kadr_pkg::STEP_BITS'(kadr_pkg::KEYS - 1)) begin
                        r_step  <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_step <= r_step + kadr_pkg::STEP_BITS'(1);
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            if (r_clear) begin
                r_out <= '0;
            end else begin
                r_out.pressed_mask   <= w_pressed;
                r_out.triggered_mask <= w_trig;
                r_out.repeated_mask  <= w_rep;
                r_out.released_mask  <= w_rel;
                r_out.dir_four       <= w_dir_four;
                r_out.dir_eight      <= w_dir_eight;
            end
        end
    end

endmodule

>>> rtl/kadr_checker.sv
// ----------------------------------------------------------------------------
// Key auto-repeat direction resolver checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module kadr_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  kadr_pkg::t_out_res                   o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result changed or was dropped.");

    a_trig_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.triggered_mask & ~o_out_data.pressed_mask) == '0))
        else $error("Triggered key is not pressed.");

    a_rel_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.released_mask & o_out_data.pressed_mask) == '0))
        else $error("Released key is still pressed.");

    a_dir_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.dir_four != kadr_pkg::DIR_NONE)
        |-> (o_out_data.pressed_mask != '0) && (o_out_data.dir_eight != kadr_pkg::DIR_NONE))
        else $error("Direction reported without a pressed key.");

endmodule

bind key_autorepeat_direction_resolver kadr_checker u_kadr_checker (.*);
